// ----- design/zzs_pkg.sv -----
// ----------------------------------------------------------------------------
// zzs_pkg
// Shared types, constants and scan tables for the zig-zag scanner.
// ----------------------------------------------------------------------------
package zzs_pkg;

	// Field widths fixed by the interface
	localparam int COEF_PORT_BITS = 16;
	localparam int VALUE_BITS     = 17;
	localparam int POS_BITS       = 6;
	localparam int MASK_BITS      = 64;
	localparam int LEN_BITS       = 7;

	// Ping-pong storage: two banks of one 8x8 block each
	localparam int BANK_DEPTH = 64;
	localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
	localparam int ADDR_BITS  = 7;

	// Configuration register indexes
	localparam int REG_IDX_BITS = 1;
	localparam int CFG_BITS     = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_BLOCK_SIZE     = 1'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_MAGNITUDE_MODE = 1'd1;

	// Block lengths and last scan positions
	localparam logic [LEN_BITS-1:0] LEN_4X4  = 7'd16;
	localparam logic [LEN_BITS-1:0] LEN_8X8  = 7'd64;
	localparam logic [POS_BITS-1:0] LAST_4X4 = 6'd15;
	localparam logic [POS_BITS-1:0] LAST_8X8 = 6'd63;

	// Frame zig-zag order, raster index per scan position
	localparam logic [3:0] SCAN4 [16] = '{
		4'd0, 4'd1, 4'd4, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6,
		4'd9, 4'd12, 4'd13, 4'd10, 4'd7, 4'd11, 4'd14, 4'd15
	};

	localparam logic [5:0] SCAN8 [64] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

	// One loaded block waiting to be scanned out
	typedef struct packed {
		logic bank;
		logic size8;
		logic mag;
	} desc_t;

	// Back end hands a bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	// Back-end sequencer
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} scan_state_t;

endpackage

// ----- design/zzs_ram.sv -----
// ----------------------------------------------------------------------------
// zzs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module zzs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- design/zzs_fifo.sv -----
// ----------------------------------------------------------------------------
// zzs_fifo
// Two-entry queue of block descriptors between the load and scan sides.
// ----------------------------------------------------------------------------
module zzs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  zzs_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output zzs_pkg::desc_t head_desc
);
	import zzs_pkg::*;

	desc_t      entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_desc  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/zzs_front.sv -----
// ----------------------------------------------------------------------------
// zzs_front
// Load side: holds the configuration, writes raster-order coefficients into
// the free bank and queues a descriptor once a block is complete.
// ----------------------------------------------------------------------------
module zzs_front #(
	parameter int COEF_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [zzs_pkg::REG_IDX_BITS-1:0]     cfg_index,
	input  logic [zzs_pkg::CFG_BITS-1:0]         cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [zzs_pkg::COEF_PORT_BITS-1:0]   coefficient,
	output logic                                 wr_en,
	output logic [zzs_pkg::ADDR_BITS-1:0]        wr_addr,
	output logic [COEF_BITS-1:0]                 wr_data,
	output logic                                 push,
	output zzs_pkg::desc_t                       push_desc,
	input  logic                                 fifo_full,
	input  zzs_pkg::release_t                    rel
);
	import zzs_pkg::*;

	logic                size8_q;
	logic                mag_q;
	logic [POS_BITS-1:0] count_q;
	logic                bank_q;
	logic [1:0]          busy_q;

	logic                accept;
	logic [LEN_BITS-1:0] count_inc;
	logic [LEN_BITS-1:0] len;
	logic                done;

	// Request handshake and block completion
	assign in_stall  = busy_q[bank_q] || fifo_full;
	assign accept    = in_valid && !in_stall;
	assign count_inc = {1'b0, count_q} + 7'd1;
	assign len       = size8_q ? LEN_8X8 : LEN_4X4;
	assign done      = (count_inc >= len);

	// Store write
	assign wr_en   = accept;
	assign wr_addr = {bank_q, count_q};
	assign wr_data = coefficient[COEF_BITS-1:0];

	// Descriptor for the back end
	assign push            = accept && done;
	assign push_desc.bank  = bank_q;
	assign push_desc.size8 = size8_q;
	assign push_desc.mag   = mag_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size8_q <= 1'b0;
			mag_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_SIZE:     size8_q <= cfg_data[0];
				REG_MAGNITUDE_MODE: mag_q   <= cfg_data[0];
				default:            size8_q <= size8_q;
			endcase
		end
	end

	// Load count, bank select and bank ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bank_q  <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			if (accept) begin
				if (done) begin
					count_q <= '0;
					bank_q  <= !bank_q;
				end else begin
					count_q <= count_inc[POS_BITS-1:0];
				end
			end
			for (int b = 0; b < 2; b++) begin
				if (push && (bank_q == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (rel.valid && (rel.bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- design/zzs_back.sv -----
// ----------------------------------------------------------------------------
// zzs_back
// Scan side: walks a loaded bank in zig-zag order (one read per cycle unless
// stalled), driving the result register: value, position, mask, large flag.
// ----------------------------------------------------------------------------
module zzs_back #(
	parameter int COEF_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  zzs_pkg::desc_t                      head_desc,
	output logic                                pop,
	output logic                                rd_en,
	output logic [zzs_pkg::ADDR_BITS-1:0]       rd_addr,
	input  logic [COEF_BITS-1:0]                rd_data,
	output zzs_pkg::release_t                   rel,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [zzs_pkg::VALUE_BITS-1:0] scanned_value,
	output logic [zzs_pkg::POS_BITS-1:0]        scan_position,
	output logic                                last_of_block,
	output logic [zzs_pkg::MASK_BITS-1:0]       nonzero_mask,
	output logic                                has_large
);
	import zzs_pkg::*;

	scan_state_t         state_q;
	scan_state_t         state_d;
	desc_t               cur_q;
	logic [POS_BITS-1:0] k_q;

	// Read stage
	logic                valid_s1;
	logic [POS_BITS-1:0] k_s1;
	logic                last_s1;
	logic                mag_s1;

	// Result stage
	logic                        valid_s2;
	logic signed [VALUE_BITS-1:0] value_s2;
	logic [POS_BITS-1:0]         pos_s2;
	logic                        last_s2;
	logic [MASK_BITS-1:0]        mask_s2;
	logic                        large_s2;

	// Per-block accumulators
	logic [MASK_BITS-1:0] mask_q;
	logic                 large_q;

	logic                         take;
	logic                         adv;
	logic                         issue;
	logic [POS_BITS-1:0]          last_idx;
	logic                         issue_last;
	logic [POS_BITS-1:0]          raster;
	logic signed [VALUE_BITS-1:0] sx;
	logic signed [VALUE_BITS-1:0] val;
	logic                         nz;
	logic                         big;
	logic [MASK_BITS-1:0]         mask_next;
	logic                         large_next;

	// Pipeline flow
	assign take       = valid_s2 && !out_stall;
	assign adv        = valid_s1 && (!valid_s2 || take);
	assign issue      = (state_q == ST_RUN) && (!valid_s1 || adv);
	assign last_idx   = cur_q.size8 ? LAST_8X8 : LAST_4X4;
	assign issue_last = issue && (k_q == last_idx);

	// Zig-zag address
	assign raster  = cur_q.size8 ? SCAN8[k_q] : {2'b00, SCAN4[k_q[3:0]]};

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue_last && !head_valid) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = {cur_q.bank, raster};
		rel.valid = 1'b0;
		rel.bank  = cur_q.bank;
		unique case (state_q)
			ST_IDLE: begin
				pop = head_valid;
			end
			ST_RUN: begin
				rd_en     = issue;
				rel.valid = issue_last;
				pop       = issue_last && head_valid;
			end
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_desc;
		end
	end

	// Read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			k_s1    <= k_q;
			last_s1 <= (k_q == last_idx);
			mag_s1  <= cur_q.mag;
		end
	end

	// Value, magnitude and classification
	assign sx         = {{(VALUE_BITS - COEF_BITS){rd_data[COEF_BITS-1]}}, rd_data};
	assign val        = (mag_s1 && rd_data[COEF_BITS-1]) ? -sx : sx;
	assign nz         = |rd_data;
	assign big        = (sx > 17'sd1) || (sx < -17'sd1);
	assign mask_next  = mask_q | (nz ? (64'd1 << k_s1) : '0);
	assign large_next = large_q || big;

	// Result stage control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			mask_q   <= '0;
			large_q  <= 1'b0;
		end else begin
			if (adv) begin
				valid_s2 <= 1'b1;
				if (last_s1) begin
					mask_q  <= '0;
					large_q <= 1'b0;
				end else begin
					mask_q  <= mask_next;
					large_q <= large_next;
				end
			end else if (take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s2 <= val;
			pos_s2   <= k_s1;
			last_s2  <= last_s1;
			mask_s2  <= last_s1 ? mask_next : '0;
			large_s2 <= last_s1 && large_next;
		end
	end

	assign out_valid     = valid_s2;
	assign scanned_value = value_s2;
	assign scan_position = pos_s2;
	assign last_of_block = last_s2;
	assign nonzero_mask  = mask_s2;
	assign has_large     = large_s2;

endmodule

// ----- design/zigzag_scan_with_nonzero_mask.sv -----
// ----------------------------------------------------------------------------
// zigzag_scan_with_nonzero_mask
// Collects 4x4 or 8x8 coefficient blocks in raster order and emits them in
// frame zig-zag order with a nonzero mask and a large-coefficient flag.
// ----------------------------------------------------------------------------
// Throughput: up to one coefficient in and one result out per cycle while
//   neither side is stalled; a bank frees only as its last read issues.
// Latency: with the scan side idle, the first result follows the last
//   coefficient through the queue, sequencer, registered read and result
//   register.
// Reset: asynchronous; clears control, configuration and accumulators only.
// ----------------------------------------------------------------------------
module zigzag_scan_with_nonzero_mask #(
	parameter int COEF_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [zzs_pkg::REG_IDX_BITS-1:0]       cfg_index,
	input  logic [zzs_pkg::CFG_BITS-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [zzs_pkg::COEF_PORT_BITS-1:0]     coefficient,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [zzs_pkg::VALUE_BITS-1:0]  scanned_value,
	output logic [zzs_pkg::POS_BITS-1:0]           scan_position,
	output logic                                   last_of_block,
	output logic [zzs_pkg::MASK_BITS-1:0]          nonzero_mask,
	output logic                                   has_large
);
	import zzs_pkg::*;

	logic                 wr_en;
	logic [ADDR_BITS-1:0] wr_addr;
	logic [COEF_BITS-1:0] wr_data;
	logic                 rd_en;
	logic [ADDR_BITS-1:0] rd_addr;
	logic [COEF_BITS-1:0] rd_data;
	logic                 push;
	desc_t                push_desc;
	logic                 fifo_full;
	logic                 pop;
	logic                 head_valid;
	desc_t                head_desc;
	release_t             rel;

	// Load side
	zzs_front #(
		.COEF_BITS(COEF_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.coefficient(coefficient),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.push       (push),
		.push_desc  (push_desc),
		.fifo_full  (fifo_full),
		.rel        (rel)
	);

	// Ping-pong coefficient store
	zzs_ram #(
		.WIDTH(COEF_BITS),
		.DEPTH(RAM_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Block queue
	zzs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (fifo_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_desc (head_desc)
	);

	// Scan side
	zzs_back #(
		.COEF_BITS(COEF_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (pop),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.rel          (rel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scanned_value(scanned_value),
		.scan_position(scan_position),
		.last_of_block(last_of_block),
		.nonzero_mask (nonzero_mask),
		.has_large    (has_large)
	);

endmodule
